// ----- rtl/tpsd_pkg.sv -----
// tpsd_pkg: shared types, widths, codes and the in-row swipe table for the
// touch pad swipe decoder; no dependencies
package tpsd_pkg;

  localparam int READING_WIDTH   = 16;
  localparam int TIME_WIDTH      = 32;
  localparam int CFG_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int PAD_COUNT       = 6;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOUCH_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDLE_TIMEOUT    = 1'd1;

  localparam logic [CFG_WIDTH-1:0] THRESHOLD_RESET = 16'd40;
  localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET   = 16'd250;

  localparam logic [2:0] PAD_NONE      = 3'd7;
  localparam logic [2:0] NO_TOUCH_CODE = 3'd6;
  localparam logic [1:0] ROW_NONE      = 2'd3;
  localparam logic [1:0] ROW_TOP       = 2'd0;
  localparam logic [1:0] ROW_BOTTOM    = 2'd1;

  localparam logic [2:0] G_NONE  = 3'd0;
  localparam logic [2:0] G_UP    = 3'd1;
  localparam logic [2:0] G_DOWN  = 3'd2;
  localparam logic [2:0] G_RIGHT = 3'd3;
  localparam logic [2:0] G_LEFT  = 3'd4;

  typedef struct packed {
    logic [READING_WIDTH-1:0] pad0_reading;
    logic [READING_WIDTH-1:0] pad1_reading;
    logic [READING_WIDTH-1:0] pad2_reading;
    logic [READING_WIDTH-1:0] pad3_reading;
    logic [READING_WIDTH-1:0] pad4_reading;
    logic [READING_WIDTH-1:0] pad5_reading;
    logic                     button_level;
    logic [TIME_WIDTH-1:0]    now_ms;
  } in_t;

  typedef struct packed {
    logic [2:0] gesture_code;
    logic       sensing_enabled;
    logic       enable_toggled;
    logic [2:0] touched_pad;
  } out_t;

  typedef logic [PAD_COUNT-1:0][READING_WIDTH-1:0] readings_t;

  function automatic logic [1:0] row_of(input logic [2:0] pad);
    row_of = (pad <= 3'd2) ? ROW_TOP : ROW_BOTTOM;
  endfunction

  // swipe within one row; pads in different rows or unknown give none
  function automatic logic [2:0] horizontal_code(input logic [2:0] from_pad,
                                                 input logic [2:0] to_pad);
    logic is_right;
    is_right = (from_pad == 3'd1 && to_pad == 3'd0) ||
               (from_pad == 3'd0 && to_pad == 3'd2) ||
               (from_pad == 3'd2 && to_pad == 3'd1) ||
               (from_pad == 3'd3 && to_pad == 3'd4) ||
               (from_pad == 3'd4 && to_pad == 3'd5) ||
               (from_pad == 3'd5 && to_pad == 3'd3);
    if (from_pad >= 3'd6 || to_pad >= 3'd6 || from_pad == to_pad ||
        row_of(from_pad) != row_of(to_pad)) begin
      horizontal_code = G_NONE;
    end else if (is_right) begin
      horizontal_code = G_RIGHT;
    end else begin
      horizontal_code = G_LEFT;
    end
  endfunction

endpackage

// ----- rtl/tpsd_pad_select.sv -----
// tpsd_pad_select: priority pick of the lowest touched pad
// depends on tpsd_pkg
module tpsd_pad_select (
  input  tpsd_pkg::readings_t            readings,
  input  logic [tpsd_pkg::CFG_WIDTH-1:0] threshold,
  output logic [2:0]                     pad
);
  import tpsd_pkg::*;

  logic [PAD_COUNT-1:0] hit;

  // zero reading never counts as a touch
  always_comb begin
    for (int i = 0; i < PAD_COUNT; i++) begin
      hit[i] = (readings[i] != '0) &&
               (CFG_WIDTH'(readings[i]) < threshold);
    end
  end

  always_comb begin
    pad = PAD_NONE;
    for (int i = PAD_COUNT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        pad = 3'(i);
      end
    end
  end

endmodule

// ----- rtl/touch_pad_swipe_decoder.sv -----
// touch_pad_swipe_decoder: top level, scan register, gesture state and
// result register; depends on tpsd_pkg and tpsd_pad_select
//
// One scan request in, one result request out, in order. A scan lands in an
// input register; from there a single pass of compare and select logic
// (touch pick, idle timeout, row and swipe decision) updates the gesture
// state and loads the result register once that register is empty or being
// drained. Throughput is one scan per clock while the result side takes one
// per clock. A scan passes the input register and then the result register
// before its result shows on out_valid. The input register frees as soon as
// its scan moves into the result register, so a new scan is taken while an
// earlier result still waits. Configuration writes on the cfg port take
// effect at once and are meant for when no scan is in flight.
module touch_pad_swipe_decoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  tpsd_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output tpsd_pkg::out_t                       out_data,
  input  logic                                 cfg_we,
  input  logic [tpsd_pkg::CFG_INDEX_WIDTH-1:0] cfg_addr,
  input  logic [tpsd_pkg::CFG_WIDTH-1:0]       cfg_wdata
);
  import tpsd_pkg::*;

  // configuration
  logic [CFG_WIDTH-1:0] threshold_r;
  logic [CFG_WIDTH-1:0] timeout_r;

  // scan register and result register
  logic s1_valid_r;
  in_t  s1_data_r;
  logic out_valid_r;
  out_t out_data_r;
  out_t out_data_nxt;
  logic advance;

  // gesture state
  logic                  enable_r,     enable_nxt;
  logic                  prev_btn_r,   prev_btn_nxt;
  logic [2:0]            prev_pad_r,   prev_pad_nxt;
  logic [2:0]            row_pad_r,    row_pad_nxt;
  logic [1:0]            prev_row_r,   prev_row_nxt;
  logic [TIME_WIDTH-1:0] last_time_r,  last_time_nxt;
  logic                  vert_r,       vert_nxt;
  logic                  vert_down_r,  vert_down_nxt;

  readings_t             readings;
  logic [2:0]            pick;
  logic [2:0]            pad;
  logic [1:0]            row;
  logic                  toggled;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [2:0]            code;

  // scan moves on when the result register is empty or being drained
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign readings[0] = s1_data_r.pad0_reading;
  assign readings[1] = s1_data_r.pad1_reading;
  assign readings[2] = s1_data_r.pad2_reading;
  assign readings[3] = s1_data_r.pad3_reading;
  assign readings[4] = s1_data_r.pad4_reading;
  assign readings[5] = s1_data_r.pad5_reading;

  tpsd_pad_select u_pad_select (
    .readings  (readings),
    .threshold (threshold_r),
    .pad       (pick)
  );

  // modular time since last touch, wrap handled by the subtract width
  assign elapsed = s1_data_r.now_ms - last_time_r;

  always_comb begin
    toggled       = !s1_data_r.button_level && prev_btn_r;
    enable_nxt    = enable_r ^ toggled;
    prev_btn_nxt  = s1_data_r.button_level;
    prev_pad_nxt  = prev_pad_r;
    row_pad_nxt   = row_pad_r;
    prev_row_nxt  = prev_row_r;
    last_time_nxt = last_time_r;
    vert_nxt      = vert_r;
    vert_down_nxt = vert_down_r;
    code          = G_NONE;
    // pads are ignored entirely while sensing is off
    pad           = enable_nxt ? pick : PAD_NONE;
    row           = row_of(pad);

    if (enable_nxt) begin
      if (pad == PAD_NONE) begin
        // idle long enough: forget the gesture in progress
        if (elapsed > TIME_WIDTH'(timeout_r)) begin
          prev_pad_nxt  = PAD_NONE;
          row_pad_nxt   = PAD_NONE;
          prev_row_nxt  = ROW_NONE;
          vert_nxt      = 1'b0;
          vert_down_nxt = 1'b0;
        end
      end else begin
        last_time_nxt = s1_data_r.now_ms;
        if (!vert_r && prev_row_r != ROW_NONE && row != prev_row_r) begin
          // row change latches vertical mode
          if (prev_row_r == ROW_TOP) begin
            code          = G_UP;
            vert_down_nxt = 1'b0;
          end else begin
            code          = G_DOWN;
            vert_down_nxt = 1'b1;
          end
          vert_nxt = 1'b1;
        end else if (vert_r && pad != prev_pad_r) begin
          // latched: any pad change repeats the direction
          code = vert_down_r ? G_DOWN : G_UP;
        end else if (!vert_r) begin
          code        = horizontal_code(row_pad_r, pad);
          row_pad_nxt = pad;
        end
        prev_row_nxt = row;
        prev_pad_nxt = pad;
      end
    end
  end

  always_comb begin
    out_data_nxt.gesture_code    = code;
    out_data_nxt.sensing_enabled = enable_nxt;
    out_data_nxt.enable_toggled  = toggled;
    out_data_nxt.touched_pad     = (pad == PAD_NONE) ? NO_TOUCH_CODE : pad;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      timeout_r   <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TOUCH_THRESHOLD: threshold_r <= cfg_wdata;
        CFG_IDLE_TIMEOUT:    timeout_r   <= cfg_wdata;
        default:             ;
      endcase
    end
  end

  // scan register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  // gesture state commits as the scan moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      prev_btn_r  <= 1'b1;
      prev_pad_r  <= PAD_NONE;
      row_pad_r   <= PAD_NONE;
      prev_row_r  <= ROW_NONE;
      last_time_r <= '0;
      vert_r      <= 1'b0;
      vert_down_r <= 1'b0;
    end else if (advance) begin
      enable_r    <= enable_nxt;
      prev_btn_r  <= prev_btn_nxt;
      prev_pad_r  <= prev_pad_nxt;
      row_pad_r   <= row_pad_nxt;
      prev_row_r  <= prev_row_nxt;
      last_time_r <= last_time_nxt;
      vert_r      <= vert_nxt;
      vert_down_r <= vert_down_nxt;
    end
  end

endmodule
